// ===== rtl/wmbh_pkg.sv =====
// shared types, constants and helper functions of the word multiply byte hash
package wmbh_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned COUNT_W = 4;

    localparam logic [WORD_W-1:0]  HASH_SEED  = 64'd5381;
    localparam logic [HALF_W-1:0]  PRIME_LO   = 32'hf12a_e399;
    localparam logic [HALF_W-1:0]  PRIME_HI   = 32'hca7c_2633;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    // hash value kept as partial products of the 64-bit multiply plus an addend;
    // value = ll + ((lh + hl) << 32) + add, all modulo 2^64
    typedef struct packed {
        logic [WORD_W-1:0] ll;
        logic [HALF_W-1:0] lh;
        logic [HALF_W-1:0] hl;
        logic [WORD_W-1:0] add;
    } t_part;

    function automatic logic [WORD_W-1:0] bswap64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pp_sum(
        input logic [WORD_W-1:0] ll,
        input logic [HALF_W-1:0] lh,
        input logic [HALF_W-1:0] hl
    );
        logic [HALF_W-1:0] mid;
        mid = lh + hl;
        return ll + {mid, {HALF_W{1'b0}}};
    endfunction

endpackage

// ===== rtl/wmbh_core.sv =====
// hash state, absorb multiply and final addend selection
module wmbh_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [wmbh_pkg::WORD_W-1:0] i_word,
    input  logic [wmbh_pkg::COUNT_W-1:0] i_bytes,
    input  logic                        i_last,
    output wmbh_pkg::t_part             o_part
);

    logic [wmbh_pkg::WORD_W-1:0] r_hash_ll;
    logic [wmbh_pkg::HALF_W-1:0] r_hash_lh;
    logic [wmbh_pkg::HALF_W-1:0] r_hash_hl;
    logic [wmbh_pkg::WORD_W-1:0] r_pend;
    logic                        r_have;

    logic [wmbh_pkg::WORD_W-1:0]  h_cur;
    logic [wmbh_pkg::WORD_W-1:0]  x_mix;
    logic [wmbh_pkg::WORD_W-1:0]  pp_ll;
    logic [wmbh_pkg::HALF_W-1:0]  pp_lh;
    logic [wmbh_pkg::HALF_W-1:0]  pp_hl;
    logic [wmbh_pkg::COUNT_W-1:0] k_norm;
    logic [5:0]                   sh;
    logic [6:0]                   sh_inv;
    logic [wmbh_pkg::WORD_W-1:0]  tail;
    logic [wmbh_pkg::WORD_W-1:0]  mask;

    assign h_cur = wmbh_pkg::pp_sum(r_hash_ll, r_hash_lh, r_hash_hl);
    assign x_mix = wmbh_pkg::bswap64(h_cur) ^ r_pend;

    // low 64 bits of x * prime from three 32x32 products
    assign pp_ll = 64'(x_mix[31:0]) * 64'(wmbh_pkg::PRIME_LO);
    assign pp_lh = 32'(x_mix[31:0] * wmbh_pkg::PRIME_HI);
    assign pp_hl = 32'(x_mix[63:32] * wmbh_pkg::PRIME_LO);

    // out-of-range byte counts count as a full word
    assign k_norm = (i_bytes == '0 || i_bytes > wmbh_pkg::FULL_COUNT)
                    ? wmbh_pkg::FULL_COUNT : i_bytes;
    assign sh     = {k_norm[2:0], 3'b000};
    assign sh_inv = 7'd64 - {1'b0, sh};
    assign tail   = (r_pend >> sh) | (i_word << sh_inv);
    assign mask   = ~({wmbh_pkg::WORD_W{1'b1}} << sh);

    always_comb begin
        if (r_have) begin
            o_part.ll  = pp_ll;
            o_part.lh  = pp_lh;
            o_part.hl  = pp_hl;
            o_part.add = (k_norm == wmbh_pkg::FULL_COUNT) ? i_word : tail;
        end else if (k_norm == wmbh_pkg::FULL_COUNT) begin
            o_part.ll  = r_hash_ll;
            o_part.lh  = r_hash_lh;
            o_part.hl  = r_hash_hl;
            o_part.add = i_word;
        end else begin
            // short message: its bytes alone
            o_part.ll  = '0;
            o_part.lh  = '0;
            o_part.hl  = '0;
            o_part.add = i_word & mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_hash_ll <= wmbh_pkg::HASH_SEED;
            r_hash_lh <= '0;
            r_hash_hl <= '0;
            r_pend    <= '0;
            r_have    <= 1'b0;
        end else if (i_fire) begin
            if (r_have) begin
                r_hash_ll <= pp_ll;
                r_hash_lh <= pp_lh;
                r_hash_hl <= pp_hl;
            end
            r_pend <= i_word;
            r_have <= 1'b1;
        end
    end

endmodule

// ===== rtl/wmbh_out.sv =====
// output register summing partial products and addend
module wmbh_out (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  wmbh_pkg::t_part             i_part,
    output logic [wmbh_pkg::WORD_W-1:0] o_hash
);

    logic [wmbh_pkg::WORD_W-1:0] r_hash;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hash <= wmbh_pkg::pp_sum(i_part.ll, i_part.lh, i_part.hl) + i_part.add;
        end
    end

    assign o_hash = r_hash;

endmodule

// ===== rtl/word_multiply_byte_hash.sv =====
// top level of the word multiply byte hash
//
// usage
//   slave stream carries message words: tdata[63:0] eight bytes, first byte
//   in bits 7:0; tdata[67:64] count of valid low bytes (1..8, only the last
//   word may be partial, 0 or above 8 counts as 8); tdata[71:68] unused;
//   tlast marks the final word. master stream gives one 64-bit hash per
//   message, on the transaction that follows its tlast word.
// pipeline and throughput
//   one word per cycle sustained while slave tready is high. a message's
//   last word passes an input register, a partial-product register and
//   the output register before its hash is valid.
//   the loop that sets the rate is the absorb step: running hash sum, byte
//   swap, xor and three 32x32 multiplies, with the hash stored as partial
//   products so each word needs only that one pass.
// reset
//   synchronous, active low: pipeline emptied and hash state back to the seed.
// stall
//   when the master side holds tready low, the result stays in the output
//   register and the next one waits in the partial-product register; words
//   keep flowing until a third message end has nowhere to go, then slave
//   tready drops.
module word_multiply_byte_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // data_word[63:0], bytes_valid[67:64], zero pad
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // hash_value[63:0]
);

    // input register
    logic                         r_a_valid;
    logic [wmbh_pkg::WORD_W-1:0]  r_a_word;
    logic [wmbh_pkg::COUNT_W-1:0] r_a_bytes;
    logic                         r_a_last;

    // partial-product register, holds only message ends
    logic            r_b_valid;
    wmbh_pkg::t_part r_b_part;

    // output register valid
    logic r_c_valid;

    wmbh_pkg::t_part n_part;
    logic            c_free;
    logic            b_free;
    logic            a_fire;
    logic            a_free;
    logic            s_accept;

    assign c_free   = !r_c_valid || i_m_axis_tready;
    assign b_free   = !r_b_valid || c_free;
    // words that end no message never wait on the output side
    assign a_fire   = r_a_valid && (!r_a_last || b_free);
    assign a_free   = !r_a_valid || a_fire;
    assign s_accept = i_s_axis_tvalid && a_free;

    assign o_s_axis_tready = a_free;
    assign o_m_axis_tvalid = r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_s_axis_tvalid;
            end
            if (b_free) begin
                r_b_valid <= a_fire && r_a_last;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_word  <= i_s_axis_tdata[63:0];
            r_a_bytes <= i_s_axis_tdata[67:64];
            r_a_last  <= i_s_axis_tlast;
        end
        if (a_fire && r_a_last) begin
            r_b_part <= n_part;
        end
    end

    wmbh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (a_fire),
        .i_word  (r_a_word),
        .i_bytes (r_a_bytes),
        .i_last  (r_a_last),
        .o_part  (n_part)
    );

    wmbh_out u_out (
        .i_clk  (i_clk),
        .i_load (c_free && r_b_valid),
        .i_part (r_b_part),
        .o_hash (o_m_axis_tdata)
    );

endmodule

// ===== rtl/wmbh_check.sv =====
// port-level checks for the word multiply byte hash, bound to the top level
module wmbh_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);

    // the output shows no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid ##1 !o_m_axis_tvalid)
        else $error("result shown too soon after reset");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // the input only stalls behind a result the receiver is holding off
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a stalled result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind word_multiply_byte_hash wmbh_check u_check (.*);
